/* hdl/gce_pkg.sv */
// gce_pkg: shared types and constants for the glyph color expander
// no dependencies; used by the channel interfaces and every module of the block

package gce_pkg;

  // frame geometry and bitmap word size
  localparam int FRAME_WIDTH  = 800;
  localparam int FRAME_HEIGHT = 600;
  localparam int WORD_BITS    = 32;

  // field widths
  localparam int OFF_IN_W = 19;
  localparam int OFF_W    = 20;
  localparam int COLOR_W  = 16;
  localparam int DIM_W    = 7;
  localparam int CNT_W    = $clog2(WORD_BITS);

  // frame size, kept wide so every frame in range fits
  localparam logic [31:0] FRAME_SIZE = 32'(FRAME_WIDTH * FRAME_HEIGHT);
  localparam logic [OFF_W:0] FRAME_STEP = (OFF_W + 1)'(FRAME_WIDTH);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(16);

  // controller to datapath commands
  typedef struct packed {
    logic load;   // input request taken this cycle
    logic step;   // emit one pixel into the output register
    logic last;   // the pixel emitted is the last one of this word
  } gce_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic start_active;  // the offered request leaves a glyph in progress
    logic pix_done;      // the current pixel closes the glyph
  } gce_sts_t;

endpackage

/* hdl/gce_if.sv */
// gce channel interfaces: bitmap input, pixel output, configuration write
// depends on gce_pkg for field widths

interface gce_in_if import gce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                glyph_start;
  logic [OFF_IN_W-1:0] base_offset;
  logic [COLOR_W-1:0]  draw_color;
  logic [DIM_W-1:0]    glyph_width;
  logic [WORD_BITS-1:0] bitmap_word;

  modport source (output valid, glyph_start, base_offset, draw_color, glyph_width,
                  bitmap_word, input ready);
  modport sink   (input valid, glyph_start, base_offset, draw_color, glyph_width,
                  bitmap_word, output ready);
endinterface

interface gce_out_if import gce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OFF_W-1:0]   pixel_offset;
  logic [COLOR_W-1:0] pixel_value;
  logic               beyond_frame;
  logic               glyph_done;
  logic               last_of_word;

  modport source (output valid, pixel_offset, pixel_value, beyond_frame, glyph_done,
                  last_of_word, input ready);
  modport sink   (input valid, pixel_offset, pixel_value, beyond_frame, glyph_done,
                  last_of_word, output ready);
endinterface

interface gce_cfg_if import gce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] glyph_height;

  modport source (output valid, glyph_height, input ready);
  modport sink   (input valid, glyph_height, output ready);
endinterface

/* hdl/gce_ctrl.sv */
// gce_ctrl: sequencer that walks the bits of one bitmap word
// depends on gce_pkg for command and status types

module gce_ctrl import gce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gce_sts_t sts,
  output gce_cmd_t cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_EXPAND = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // command decode
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd.load  = in_valid && in_ready;
    cmd.step  = (state_r == ST_EXPAND) && (!out_valid_r || out_ready);
    cmd.last  = sts.pix_done || (cnt_r == LAST_BIT);
    out_valid = out_valid_r;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load && sts.start_active) begin
          state_nxt = ST_EXPAND;
          cnt_nxt   = '0;
        end
      end
      ST_EXPAND: begin
        if (cmd.step) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/gce_dp.sv */
// gce_dp: glyph position, color latch, bit shifter and pixel output register
// depends on gce_pkg for widths, frame constants and command/status types

module gce_dp import gce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gce_cmd_t             cmd,
  output gce_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [DIM_W-1:0]     cfg_height,
  input  logic                 glyph_start,
  input  logic [OFF_IN_W-1:0]  base_offset,
  input  logic [COLOR_W-1:0]   draw_color,
  input  logic [DIM_W-1:0]     glyph_width,
  input  logic [WORD_BITS-1:0] bitmap_word,
  output logic [OFF_W-1:0]     pixel_offset,
  output logic [COLOR_W-1:0]   pixel_value,
  output logic                 beyond_frame,
  output logic                 glyph_done,
  output logic                 last_of_word
);

  logic [DIM_W-1:0]     height_r;
  logic [OFF_W-1:0]     row_start_r, row_start_nxt;
  logic [DIM_W-1:0]     column_r, column_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [COLOR_W-1:0]   color_r;
  logic [DIM_W-1:0]     width_r;
  logic                 active_r, active_nxt;
  logic [WORD_BITS-1:0] word_r;

  logic [OFF_W:0]       addr_sum;
  logic [OFF_W-1:0]     addr;
  logic [OFF_W:0]       next_row_sum;
  logic                 row_end;

  logic [OFF_W-1:0]     pix_off_r;
  logic [COLOR_W-1:0]   pix_val_r;
  logic                 pix_beyond_r;
  logic                 pix_done_r;
  logic                 pix_last_r;

  // current pixel address and end of row / glyph checks
  always_comb begin
    addr_sum     = {1'b0, row_start_r} + (OFF_W + 1)'(column_r);
    addr         = addr_sum[OFF_W] ? '1 : addr_sum[OFF_W-1:0];
    next_row_sum = {1'b0, row_start_r} + FRAME_STEP;
    row_end      = ({1'b0, column_r} + 1'b1) >= {1'b0, width_r};
    sts.pix_done = row_end && (({1'b0, row_r} + 1'b1) >= {1'b0, height_r});
    sts.start_active = glyph_start ? ((glyph_width != '0) && (height_r != '0)) : active_r;
  end

  // position update for one pixel step
  always_comb begin
    row_start_nxt = row_start_r;
    column_nxt    = column_r;
    row_nxt       = row_r;
    active_nxt    = active_r;
    if (row_end) begin
      column_nxt    = '0;
      row_nxt       = row_r + 1'b1;
      row_start_nxt = next_row_sum[OFF_W] ? '1 : next_row_sum[OFF_W-1:0];
    end else begin
      column_nxt = column_r + 1'b1;
    end
    if (sts.pix_done) begin
      active_nxt = 1'b0;
    end
  end

  // glyph height register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      height_r <= cfg_height;
    end
  end

  // glyph state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_start_r <= '0;
      column_r    <= '0;
      row_r       <= '0;
      color_r     <= '0;
      width_r     <= '0;
      active_r    <= 1'b0;
    end else if (cmd.load) begin
      if (glyph_start) begin
        row_start_r <= {1'b0, base_offset};
        column_r    <= '0;
        row_r       <= '0;
        color_r     <= draw_color;
        width_r     <= glyph_width;
        active_r    <= sts.start_active;
      end
    end else if (cmd.step) begin
      row_start_r <= row_start_nxt;
      column_r    <= column_nxt;
      row_r       <= row_nxt;
      active_r    <= active_nxt;
    end
  end

  // bitmap shifter, bit 0 first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= bitmap_word;
    end else if (cmd.step) begin
      word_r <= word_r >> 1;
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pix_off_r    <= addr;
      pix_val_r    <= word_r[0] ? color_r : '0;
      pix_beyond_r <= 32'(addr) >= FRAME_SIZE;
      pix_done_r   <= sts.pix_done;
      pix_last_r   <= cmd.last;
    end
  end

  assign pixel_offset = pix_off_r;
  assign pixel_value  = pix_val_r;
  assign beyond_frame = pix_beyond_r;
  assign glyph_done   = pix_done_r;
  assign last_of_word = pix_last_r;

endmodule

/* hdl/glyph_color_expander.sv */
// glyph_color_expander: one-bit-per-pixel glyph to 16-bit pixel write expansion
// pixels: the word is loaded into the shifter, then one pixel per cycle enters the output reg
//   while the output is not stalled; a word gives up to 32 pixels, set by the single pixel step
//   of the datapath; the next word is taken once the last pixel enters the output reg
// reset: synchronous active low; no glyph in progress, glyph_height returns to 16
// depends on gce_pkg, gce_if, gce_ctrl and gce_dp

module glyph_color_expander import gce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gce_in_if.sink     in_if,
  gce_out_if.source  out_if,
  gce_cfg_if.sink    cfg_if
);

  gce_cmd_t cmd;
  gce_sts_t sts;

  // configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  // bit sequencer
  gce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // glyph datapath
  gce_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_if.valid),
    .cfg_height   (cfg_if.glyph_height),
    .glyph_start  (in_if.glyph_start),
    .base_offset  (in_if.base_offset),
    .draw_color   (in_if.draw_color),
    .glyph_width  (in_if.glyph_width),
    .bitmap_word  (in_if.bitmap_word),
    .pixel_offset (out_if.pixel_offset),
    .pixel_value  (out_if.pixel_value),
    .beyond_frame (out_if.beyond_frame),
    .glyph_done   (out_if.glyph_done),
    .last_of_word (out_if.last_of_word)
  );

endmodule

/* dv/tb_glyph_color_expander.sv */
`timescale 1ns / 100ps
// tb_glyph_color_expander: self-checking bench for the glyph color expander, directed table
// then random glyph sequences under several idle and stall patterns
// depends on gce_pkg, the gce channel interfaces and the glyph_color_expander rtl

module tb_glyph_color_expander import gce_pkg::*; ();

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 80;
  localparam int MAX_SEQ_WORDS  = 16;
  localparam int PLAN_LEN       = 24;
  localparam int unsigned OFFSET_CEIL = (1 << OFF_W) - 1;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic                 glyph_start;
    logic [OFF_IN_W-1:0]  base_offset;
    logic [COLOR_W-1:0]   draw_color;
    logic [DIM_W-1:0]     glyph_width;
    logic [WORD_BITS-1:0] bitmap_word;
  } bitmap_req_t;

  typedef struct packed {
    logic [OFF_W-1:0]   offset;
    logic [COLOR_W-1:0] value;
    logic               beyond;
    logic               done;
    logic               last;
  } pixel_t;

  // one directed row: a bitmap request or a glyph_height write (height in dim);
  // typed rows carry their expected writes: none, or one closing pixel
  typedef struct packed {
    row_kind_t            kind;
    logic                 start;
    logic [OFF_IN_W-1:0]  base;
    logic [COLOR_W-1:0]   color;
    logic [DIM_W-1:0]     dim;
    logic [WORD_BITS-1:0] word;
    logic                 typed;
    logic                 one_px;
    logic [OFF_W-1:0]     px_off;
    logic [COLOR_W-1:0]   px_val;
    logic                 px_beyond;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // word with no glyph in progress
    '{ROW_WORD, 0, 0,       'h0000, 0,   'hFFFF_FFFF, 1, 0, 0,       'h0000, 0},
    // zero width glyph
    '{ROW_WORD, 1, 5,       'hABCD, 0,   'hFFFF_FFFF, 1, 0, 0,       'h0000, 0},
    // one column over the reset height
    '{ROW_WORD, 1, 0,       'hFFFF, 1,   'h0000_FFFF, 0, 0, 0,       'h0000, 0},
    // 4 x 16 glyph spans two words exactly
    '{ROW_WORD, 1, 1000,    'hF800, 4,   'hAAAA_AAAA, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 0, 0,       'h0000, 0,   'h5555_5555, 0, 0, 0,       'h0000, 0},
    // glyph finished, word ignored
    '{ROW_WORD, 0, 0,       'h0000, 0,   'hFFFF_FFFF, 1, 0, 0,       'h0000, 0},
    // wide glyph running past the frame end
    '{ROW_WORD, 1, 479990,  'h07E0, 64,  'h1234_5678, 0, 0, 0,       'h0000, 0},
    // restart mid-glyph
    '{ROW_WORD, 1, 100,     'h001F, 3,   'hFFFF_FFFF, 0, 0, 0,       'h0000, 0},
    // height drops to 1 mid-glyph
    '{ROW_CFG,  0, 0,       'h0000, 1,   'h0000_0000, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 0, 0,       'h0000, 0,   'h0000_0000, 0, 0, 0,       'h0000, 0},
    // single pixel glyphs at the offset extremes
    '{ROW_WORD, 1, 0,       'h0000, 1,   'hFFFF_FFFF, 1, 1, 0,       'h0000, 0},
    '{ROW_WORD, 1, 479999,  'hFFFF, 1,   'h0000_0001, 1, 1, 479999,  'hFFFF, 0},
    '{ROW_WORD, 1, 480000,  'h1234, 1,   'h0000_0000, 1, 1, 480000,  'h0000, 1},
    '{ROW_WORD, 1, 'h7FFFF, 'hFFFF, 1,   'hFFFF_FFFF, 1, 1, 'h7FFFF, 'hFFFF, 1},
    // widest glyph, one row: four words, last bit of the last word left over
    '{ROW_WORD, 1, 0,       'h8001, 127, 'hFFFF_FFFF, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 0, 0,       'h0000, 0,   'h0000_0000, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 0, 0,       'h0000, 0,   'h0F0F_0F0F, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 0, 0,       'h0000, 0,   'h8000_0001, 0, 0, 0,       'h0000, 0},
    // zero height: glyph start gives nothing
    '{ROW_CFG,  0, 0,       'h0000, 0,   'h0000_0000, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 1, 10,      'hFFFF, 5,   'hFFFF_FFFF, 1, 0, 0,       'h0000, 0},
    // tallest glyph cut short by a height change mid-glyph
    '{ROW_CFG,  0, 0,       'h0000, 127, 'h0000_0000, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 1, 200,     'h7BEF, 1,   'hC3C3_C3C3, 0, 0, 0,       'h0000, 0},
    '{ROW_CFG,  0, 0,       'h0000, 2,   'h0000_0000, 0, 0, 0,       'h0000, 0},
    '{ROW_WORD, 0, 0,       'h0000, 0,   'hFFFF_FFFF, 0, 0, 0,       'h0000, 0}
  };

  logic clk;
  logic rst_n;

  gce_in_if  in_if ();
  gce_out_if out_if ();
  gce_cfg_if cfg_if ();

  glyph_color_expander u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // expander state as the bench sees it
  logic [OFF_W-1:0]   pen_row_start;
  logic [DIM_W-1:0]   pen_col;
  logic [DIM_W-1:0]   pen_row;
  logic [COLOR_W-1:0] pen_color;
  logic [DIM_W-1:0]   pen_width;
  logic               drawing;
  logic [DIM_W-1:0]   rows_per_glyph;

  pixel_t pixel_q [$];
  int     mismatches = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // expand one accepted request into the pixel writes it causes
  function automatic void expand_word(input bitmap_req_t r, ref pixel_t batch[$]);
    int unsigned addr;
    int unsigned next_row;
    int          b;
    bit          fin;
    pixel_t      px;
    batch.delete();
    if (r.glyph_start) begin
      pen_row_start = OFF_W'(r.base_offset);
      pen_color     = r.draw_color;
      pen_width     = r.glyph_width;
      pen_col       = '0;
      pen_row       = '0;
      drawing       = (pen_width != 0) && (rows_per_glyph != 0);
    end
    for (b = 0; b < WORD_BITS && drawing; b++) begin
      addr = 32'(pen_row_start) + 32'(pen_col);
      if (addr > OFFSET_CEIL) addr = OFFSET_CEIL;
      fin = 1'b0;
      // end of a row: next frame line, glyph closes on its last row
      if (32'(pen_col) + 1 >= 32'(pen_width)) begin
        fin      = (32'(pen_row) + 1 >= 32'(rows_per_glyph));
        pen_col  = '0;
        pen_row  = pen_row + 1'b1;
        next_row = 32'(pen_row_start) + FRAME_WIDTH;
        pen_row_start = (next_row > OFFSET_CEIL) ? OFF_W'(OFFSET_CEIL) : OFF_W'(next_row);
      end else begin
        pen_col = pen_col + 1'b1;
      end
      px.offset = addr[OFF_W-1:0];
      px.value  = r.bitmap_word[b] ? pen_color : '0;
      px.beyond = (addr >= FRAME_SIZE);
      px.done   = fin;
      px.last   = 1'b0;
      batch.push_back(px);
      if (fin) drawing = 1'b0;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_bits();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return WORD_BITS'($urandom);
  endfunction

  function automatic bitmap_req_t any_request();
    bitmap_req_t r;
    r.glyph_start = 1'($urandom_range(1));
    r.base_offset = OFF_IN_W'($urandom);
    r.draw_color  = COLOR_W'($urandom);
    r.glyph_width = DIM_W'($urandom);
    r.bitmap_word = pick_bits();
    return r;
  endfunction

  // offer one request, sender gaps per the current idle rate
  task automatic offer(input bitmap_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.glyph_start <= r.glyph_start;
    in_if.base_offset <= r.base_offset;
    in_if.draw_color  <= r.draw_color;
    in_if.glyph_width <= r.glyph_width;
    in_if.bitmap_word <= r.bitmap_word;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // send a request and queue its expected writes; counted is 0 for an ignored word
  task automatic deliver(input bitmap_req_t r, input bit typed, input bit one_px,
                         input pixel_t t_px, output bit counted);
    pixel_t batch [$];
    counted = r.glyph_start || drawing;
    offer(r);
    expand_word(r, batch);
    if (typed) begin
      batch.delete();
      if (one_px) batch.push_back(t_px);
    end
    foreach (batch[i]) pixel_q.push_back(batch[i]);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // register write only with the block idle
  task automatic write_height(input logic [DIM_W-1:0] h);
    drain_pixels();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.glyph_height <= h;
    do @(posedge clk); while (!cfg_if.ready);
    rows_per_glyph = h;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly a well formed glyph: start word plus its words, sometimes cut short
  // or followed by a stray word; otherwise a single noise word
  task automatic glyph_sequence(output int counted);
    bitmap_req_t r;
    int          w;
    int          wcap;
    int          words;
    int          roll;
    bit          took;
    counted = 0;
    r = any_request();
    if ($urandom_range(99) < 8) begin
      deliver(r, 1'b0, 1'b0, '0, took);
      counted = int'(took);
    end else begin
      r.glyph_start = 1'b1;
      roll = $urandom_range(99);
      if (roll < 10)
        r.base_offset = OFF_IN_W'($urandom_range(FRAME_SIZE - 1, FRAME_SIZE - 2 * FRAME_WIDTH));
      else if (roll < 20)
        r.base_offset = OFF_IN_W'($urandom_range((1 << OFF_IN_W) - 1, FRAME_SIZE));
      else
        r.base_offset = OFF_IN_W'($urandom_range(FRAME_SIZE - 1));
      wcap = (rows_per_glyph == 0) ? 127 : 384 / int'(rows_per_glyph);
      if (wcap < 1) wcap = 1;
      if (wcap > 127) wcap = 127;
      roll = $urandom_range(99);
      if (roll < 5) w = 0;
      else if (roll < 15) w = $urandom_range(127, 1);
      else w = $urandom_range(wcap, 1);
      r.glyph_width = DIM_W'(w);
      if (w == 0 || rows_per_glyph == 0) words = 1;
      else words = (w * int'(rows_per_glyph) + WORD_BITS - 1) / WORD_BITS;
      if (words > MAX_SEQ_WORDS) words = MAX_SEQ_WORDS;
      if ($urandom_range(9) == 0) words = $urandom_range(words, 1);
      for (int k = 0; k < words; k++) begin
        if (k > 0) begin
          r = any_request();
          r.glyph_start = 1'b0;
        end
        deliver(r, 1'b0, 1'b0, '0, took);
        counted += int'(took);
      end
      if ($urandom_range(9) == 0) begin
        r = any_request();
        r.glyph_start = 1'b0;
        deliver(r, 1'b0, 1'b0, '0, took);
        counted += int'(took);
      end
    end
  endtask

  // pixel receiver: random stalls, plus one long hold-off on request
  initial begin : pixel_sink
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each accepted pixel write with the oldest expectation
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel write at offset %0d", out_if.pixel_offset);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_if.pixel_offset !== want.offset) begin
          $error("pixel_offset: expected %0d, got %0d", want.offset, out_if.pixel_offset);
          mismatches++;
        end
        if (out_if.pixel_value !== want.value) begin
          $error("pixel_value: expected %h, got %h", want.value, out_if.pixel_value);
          mismatches++;
        end
        if (out_if.beyond_frame !== want.beyond) begin
          $error("beyond_frame: expected %b, got %b", want.beyond, out_if.beyond_frame);
          mismatches++;
        end
        if (out_if.glyph_done !== want.done) begin
          $error("glyph_done: expected %b, got %b", want.done, out_if.glyph_done);
          mismatches++;
        end
        if (out_if.last_of_word !== want.last) begin
          $error("last_of_word: expected %b, got %b", want.last, out_if.last_of_word);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    bitmap_req_t r;
    pixel_t      t_px;
    bit          took;
    bit          paused;
    int          taken;
    int          n;
    int          ph;
    logic [DIM_W-1:0] phase_height;

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.glyph_start   = 1'b0;
    in_if.base_offset   = '0;
    in_if.draw_color    = '0;
    in_if.glyph_width   = '0;
    in_if.bitmap_word   = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.glyph_height = '0;

    pen_row_start  = '0;
    pen_col        = '0;
    pen_row        = '0;
    pen_color      = '0;
    pen_width      = '0;
    drawing        = 1'b0;
    rows_per_glyph = HEIGHT_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_height(PLAN[i].dim);
      end else begin
        r    = '{PLAN[i].start, PLAN[i].base, PLAN[i].color, PLAN[i].dim, PLAN[i].word};
        t_px = '{PLAN[i].px_off, PLAN[i].px_val, PLAN[i].px_beyond, 1'b1, 1'b1};
        deliver(r, PLAN[i].typed, PLAN[i].one_px, t_px, took);
      end
    end

    // random phases: none, sender gaps, receiver stalls, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          phase_height = HEIGHT_RST;
        end
        1: begin
          phase_height = DIM_W'(127);
        end
        2: begin
          phase_height = DIM_W'(1);
        end
        default: begin
          phase_height = DIM_W'(64);
        end
      endcase
      write_height(phase_height);
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      taken  = 0;
      paused = 1'b0;
      while (taken < PHASE_ITEMS) begin
        glyph_sequence(n);
        taken += n;
        // sender pause until every pending write is out
        if (ph == 2 && !paused && taken >= PHASE_ITEMS / 2) begin
          drain_pixels();
          paused = 1'b1;
        end
      end
    end

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
